[design/quaternion_pose_transform_core_macros.svh]
// Assertion macros for the quaternion pose transform core.
`ifndef QUATERNION_POSE_TRANSFORM_CORE_MACROS_SVH
`define QUATERNION_POSE_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during rst
`define QPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pose core check failed");
// next-cycle implication
`define QPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pose core check failed");
`else
`define QPT_ASSERT_IMP(lbl, ante, cons)
`define QPT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/qpt_pkg.sv]
// Types, codes and fixed-point helpers for the quaternion pose transform core.
package qpt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TX = 3'd0,
    REG_TY = 3'd1,
    REG_TZ = 3'd2,
    REG_QX = 3'd3,
    REG_QY = 3'd4,
    REG_QZ = 3'd5,
    REG_QW = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_COMPOSE = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_INVERT  = 2'd2
  } kind_t;

  localparam logic signed [31:0] Q_UNIT = 32'sh4000_0000;

  typedef logic signed [32:0] op_t;    // multiplier operand
  typedef logic signed [65:0] prod_t;  // one product
  typedef logic signed [67:0] acc_t;   // sum of four products
  typedef logic signed [37:0] rnd_t;   // sum after rounding shift

  localparam acc_t RND_HALF = 68'sd536870912;  // 2^29

  // One component of a*b from the 16 partial products p[i][j] = a[i]*b[j],
  // order x, y, z, w; rounded to nearest, ties up.
  function automatic rnd_t qmul_comp(input prod_t p [4][4], input logic [1:0] c);
    acc_t s;
    acc_t r;
    case (c)
      2'd0:    s = acc_t'(p[0][3]) + acc_t'(p[3][0]) - acc_t'(p[2][1]) + acc_t'(p[1][2]);
      2'd1:    s = acc_t'(p[1][3]) + acc_t'(p[2][0]) + acc_t'(p[3][1]) - acc_t'(p[0][2]);
      2'd2:    s = acc_t'(p[2][3]) - acc_t'(p[1][0]) + acc_t'(p[0][1]) + acc_t'(p[3][2]);
      default: s = acc_t'(p[3][3]) - acc_t'(p[0][0]) - acc_t'(p[1][1]) - acc_t'(p[2][2]);
    endcase
    r = (s + RND_HALF) >>> 30;
    return r[37:0];
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    if (v > 39'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -39'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // symmetric clamp to +-(2^32-1)
  function automatic op_t clamp33(input rnd_t v);
    if (v > 38'sd4294967295) begin
      return 33'sd4294967295;
    end else if (v < -38'sd4294967295) begin
      return -33'sd4294967295;
    end
    return v[32:0];
  endfunction

endpackage

[design/quaternion_pose_transform_core.sv]
// Each accepted item passes the stage 1 to 4 registers and then the output register;
// done is registered together with the outputs and is high while they hold the result.
// Throughput: one item per cycle; busy is always low, the five stages never stall.
// Stage 1 registers the item; stages 2 and 4 are banks of 33x33 multipliers, stages 3
// and 5 four-term sums with rounding, clamp or saturation.
// Reset (rst, synchronous): pipeline valid bits cleared, reference pose set to
// identity (zero translation, qw = 1.0). Results are never held off by the receiver.
`include "quaternion_pose_transform_core_macros.svh"
module quaternion_pose_transform_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [qpt_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [qpt_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           kind,
  input  logic signed [31:0]                   in_x,
  input  logic signed [31:0]                   in_y,
  input  logic signed [31:0]                   in_z,
  input  logic signed [31:0]                   in_qx,
  input  logic signed [31:0]                   in_qy,
  input  logic signed [31:0]                   in_qz,
  input  logic signed [31:0]                   in_qw,
  output logic                                 done,
  output logic signed [31:0]                   out_x,
  output logic signed [31:0]                   out_y,
  output logic signed [31:0]                   out_z,
  output logic signed [31:0]                   out_qx,
  output logic signed [31:0]                   out_qy,
  output logic signed [31:0]                   out_qz,
  output logic signed [31:0]                   out_qw
);
  import qpt_pkg::*;

  // reference pose
  logic signed [31:0] ref_t [3];
  logic signed [31:0] ref_q [4];

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_t[0] <= '0;
      ref_t[1] <= '0;
      ref_t[2] <= '0;
      ref_q[0] <= '0;
      ref_q[1] <= '0;
      ref_q[2] <= '0;
      ref_q[3] <= Q_UNIT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TX:  ref_t[0] <= $signed(cfg_data);
        REG_TY:  ref_t[1] <= $signed(cfg_data);
        REG_TZ:  ref_t[2] <= $signed(cfg_data);
        REG_QX:  ref_q[0] <= $signed(cfg_data);
        REG_QY:  ref_q[1] <= $signed(cfg_data);
        REG_QZ:  ref_q[2] <= $signed(cfg_data);
        REG_QW:  ref_q[3] <= $signed(cfg_data);
        default: ;  // index 7: no register
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture item, pick the rotation quaternion.
  // Invert uses the conjugate of the input, negated parts saturated to 32 bits.
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  logic [1:0]         s1_kind;
  op_t                s1_v  [4];   // vector as quaternion, w = 0
  logic signed [31:0] s1_qi [4];   // input quaternion, for compose
  op_t                s1_rq [4];   // rotation quaternion
  logic signed [31:0] in_q  [4];

  assign in_q[0] = in_qx;
  assign in_q[1] = in_qy;
  assign in_q[2] = in_qz;
  assign in_q[3] = in_qw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind  <= kind;
    s1_v[0]  <= op_t'(in_x);
    s1_v[1]  <= op_t'(in_y);
    s1_v[2]  <= op_t'(in_z);
    s1_v[3]  <= '0;
    for (int i = 0; i < 4; i++) begin
      s1_qi[i] <= in_q[i];
    end
    if (kind == KIND_INVERT) begin
      for (int i = 0; i < 3; i++) begin
        s1_rq[i] <= op_t'(sat32(-39'(in_q[i])));
      end
      s1_rq[3] <= op_t'(in_qw);
    end else begin
      for (int i = 0; i < 4; i++) begin
        s1_rq[i] <= op_t'(ref_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: partial products for q*(v,0) and for ref_q*in_q.
  // ---------------------------------------------------------------------------
  logic        s2_valid;
  logic [1:0]  s2_kind;
  op_t         s2_rq [4];
  prod_t       s2_pr [4][4];
  prod_t       s2_pc [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind <= s1_kind;
    for (int i = 0; i < 4; i++) begin
      s2_rq[i] <= s1_rq[i];
      for (int j = 0; j < 4; j++) begin
        s2_pr[i][j] <= s1_rq[i] * s1_v[j];
        s2_pc[i][j] <= op_t'(ref_q[i]) * op_t'(s1_qi[j]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round sums; clamp the intermediate t, pick the output quaternion.
  // ---------------------------------------------------------------------------
  logic               s3_valid;
  logic [1:0]         s3_kind;
  op_t                s3_t   [4];
  op_t                s3_rqc [4];  // conjugate of rotation quaternion
  logic signed [31:0] s3_oq  [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_kind <= s2_kind;
    for (int i = 0; i < 4; i++) begin
      s3_t[i] <= clamp33(qmul_comp(s2_pr, 2'(i)));
      s3_rqc[i] <= (i == 3) ? s2_rq[i] : -s2_rq[i];
      case (kind_t'(s2_kind))
        KIND_COMPOSE: s3_oq[i] <= sat32(39'(qmul_comp(s2_pc, 2'(i))));
        KIND_INVERT:  s3_oq[i] <= s2_rq[i][31:0];
        default:      s3_oq[i] <= '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: partial products for t*conj(q).
  // ---------------------------------------------------------------------------
  logic               s4_valid;
  logic [1:0]         s4_kind;
  prod_t              s4_p  [4][4];
  logic signed [31:0] s4_oq [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_kind <= s3_kind;
    for (int i = 0; i < 4; i++) begin
      s4_oq[i] <= s3_oq[i];
      for (int j = 0; j < 4; j++) begin
        s4_p[i][j] <= s3_t[i] * s3_rqc[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: round, add translation (or negate for invert), saturate, drive out.
  // ---------------------------------------------------------------------------
  logic signed [31:0] res_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (kind_t'(s4_kind))
        KIND_COMPOSE,
        KIND_POINT:  res_v[i] = sat32(39'(qmul_comp(s4_p, 2'(i))) + 39'(ref_t[i]));
        KIND_INVERT: res_v[i] = sat32(-39'(qmul_comp(s4_p, 2'(i))));
        default:     res_v[i] = '0;  // unused kind answers zero
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x  <= res_v[0];
    out_y  <= res_v[1];
    out_z  <= res_v[2];
    out_qx <= s4_oq[0];
    out_qy <= s4_oq[1];
    out_qz <= s4_oq[2];
    out_qw <= s4_oq[3];
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `QPT_ASSERT_NXT(a_item_out, accept, ##4 done)
  `QPT_ASSERT_IMP(a_out_had_item, done, $past(accept, 5))
  `QPT_ASSERT_IMP(a_point_no_quat, done && $past(kind, 5) == KIND_POINT, (out_qx == 32'sd0) && (out_qy == 32'sd0) && (out_qz == 32'sd0) && (out_qw == 32'sd0))

endmodule

[tb/sv/pose_checker.sv]
// Scoreboard for the pose core: predicts each item's result and compares on done.
`timescale 1ns / 100ps
module pose_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qpt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [qpt_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    kind,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  input  logic signed [31:0]            in_qx,
  input  logic signed [31:0]            in_qy,
  input  logic signed [31:0]            in_qz,
  input  logic signed [31:0]            in_qw,
  input  logic                          done,
  input  logic signed [31:0]            out_x,
  input  logic signed [31:0]            out_y,
  input  logic signed [31:0]            out_z,
  input  logic signed [31:0]            out_qx,
  input  logic signed [31:0]            out_qy,
  input  logic signed [31:0]            out_qz,
  input  logic signed [31:0]            out_qw,
  output int                            errors,
  output int                            pending
);
  import qpt_pkg::*;

  typedef logic signed [79:0] wide_t;
  typedef struct { wide_t c[4]; } quat_t;
  typedef struct { logic signed [31:0] f[7]; } pose_res_t;

  localparam wide_t HALF_LSB = 80'sd536870912;
  localparam wide_t MID_MAX  = 80'sd4294967295;
  localparam wide_t S32_MAX  = 80'sd2147483647;
  localparam wide_t S32_MIN  = -80'sd2147483648;

  logic signed [31:0] ref_pose [7];
  pose_res_t          expected_poses [$];
  string              field_names [7] = '{"x", "y", "z", "qx", "qy", "qz", "qw"};

  function automatic wide_t round_q30(wide_t s);
    wide_t t;
    t = s + HALF_LSB;
    return t >>> 30;
  endfunction

  function automatic logic signed [31:0] clip32(wide_t v);
    wide_t t;
    t = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return t[31:0];
  endfunction

  // Hamilton product, rounded per component, no saturation
  function automatic quat_t hamilton(quat_t a, quat_t b);
    quat_t r;
    r.c[0] = round_q30(a.c[0]*b.c[3] + a.c[3]*b.c[0] - a.c[2]*b.c[1] + a.c[1]*b.c[2]);
    r.c[1] = round_q30(a.c[1]*b.c[3] + a.c[2]*b.c[0] + a.c[3]*b.c[1] - a.c[0]*b.c[2]);
    r.c[2] = round_q30(a.c[2]*b.c[3] - a.c[1]*b.c[0] + a.c[0]*b.c[1] + a.c[3]*b.c[2]);
    r.c[3] = round_q30(a.c[3]*b.c[3] - a.c[0]*b.c[0] - a.c[1]*b.c[1] - a.c[2]*b.c[2]);
    return r;
  endfunction

  // q * (v,0) * conj(q); middle stage clamped to +-(2^32-1)
  function automatic quat_t rotate_vec(quat_t q, quat_t v);
    quat_t t;
    quat_t qc;
    int    i;
    t = hamilton(q, v);
    for (i = 0; i < 4; i++) begin
      if (t.c[i] > MID_MAX) t.c[i] = MID_MAX;
      else if (t.c[i] < -MID_MAX) t.c[i] = -MID_MAX;
    end
    qc.c[0] = -q.c[0];
    qc.c[1] = -q.c[1];
    qc.c[2] = -q.c[2];
    qc.c[3] = q.c[3];
    return hamilton(t, qc);
  endfunction

  function automatic pose_res_t predict_pose(logic [1:0] k, logic signed [31:0] f [7]);
    pose_res_t res;
    quat_t     rq;
    quat_t     iq;
    quat_t     v;
    quat_t     r;
    quat_t     p;
    int        i;
    for (i = 0; i < 7; i++) res.f[i] = '0;
    for (i = 0; i < 4; i++) begin
      rq.c[i] = wide_t'(ref_pose[REG_QX + i]);
      iq.c[i] = wide_t'(f[3 + i]);
    end
    for (i = 0; i < 3; i++) v.c[i] = wide_t'(f[i]);
    v.c[3] = '0;
    case (k)
      KIND_COMPOSE, KIND_POINT: begin
        r = rotate_vec(rq, v);
        for (i = 0; i < 3; i++) res.f[i] = clip32(r.c[i] + wide_t'(ref_pose[i]));
        if (k == KIND_COMPOSE) begin
          p = hamilton(rq, iq);
          for (i = 0; i < 4; i++) res.f[3 + i] = clip32(p.c[i]);
        end
      end
      KIND_INVERT: begin
        // conjugate saturates: -(-2^31) becomes 2^31-1
        for (i = 0; i < 3; i++) iq.c[i] = wide_t'(clip32(-iq.c[i]));
        for (i = 0; i < 4; i++) res.f[3 + i] = iq.c[i][31:0];
        r = rotate_vec(iq, v);
        for (i = 0; i < 3; i++) res.f[i] = clip32(-r.c[i]);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < 7; i++) ref_pose[i] = '0;
    ref_pose[REG_QW] = Q_UNIT;
  end

  assign pending = expected_poses.size();

  always @(posedge clk) begin
    logic signed [31:0] ins [7];
    logic signed [31:0] outs [7];
    pose_res_t          want;
    if (rst) begin
      for (int i = 0; i < 7; i++) ref_pose[i] = '0;
      ref_pose[REG_QW] = Q_UNIT;
      expected_poses.delete();
    end else begin
      if (done) begin
        outs = '{out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw};
        if (expected_poses.size() == 0) begin
          report("unexpected item", out_x, 0);
        end else begin
          want = expected_poses.pop_front();
          for (int i = 0; i < 7; i++)
            if (outs[i] !== want.f[i]) report(field_names[i], outs[i], want.f[i]);
        end
      end
      if (start && !busy) begin
        ins = '{in_x, in_y, in_z, in_qx, in_qy, in_qz, in_qw};
        expected_poses.push_back(predict_pose(kind, ins));
      end
      if (cfg_we && cfg_addr <= REG_QW) ref_pose[cfg_addr] = cfg_data;
    end
  end
endmodule

[tb/sv/tb.sv]
// Top of the pose core testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb;
  import qpt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;  // no operation: all-zero result
  localparam int         STALL_LIMIT = 2000;  // cycles with no traffic
  localparam int         DRAIN_WAIT  = 12;    // pipeline is 5 deep

  logic                 clk, rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [DATA_W-1:0]    cfg_data;
  logic                 start, busy, done;
  logic [1:0]           kind;
  logic signed [31:0]   in_x, in_y, in_z, in_qx, in_qy, in_qz, in_qw;
  logic signed [31:0]   out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw;
  int                   errors, pending;
  int                   quiet_cycles;
  bit                   gaps_on;

  quaternion_pose_transform_core dut (.*);
  pose_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: any accepted item or result resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[quaternion_pose_transform_core] ERROR");
        $finish;
      end
    end
  end

  // mix of extremes, small values and full-range noise
  function automatic logic signed [31:0] pick_val(bit quat);
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return quat ? (($urandom_range(1) != 0) ? Q_UNIT : -Q_UNIT) : 32'sd0;
      3, 4: return $urandom;
      default: return quat ? $signed($urandom_range(32'h8000_0000)) - Q_UNIT
                           : $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic send_item(logic [1:0] k, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic signed [31:0] qx,
                           logic signed [31:0] qy, logic signed [31:0] qz,
                           logic signed [31:0] qw);
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 15);
    end
    start <= 1'b1;
    kind  <= k;
    in_x  <= x;  in_y  <= y;  in_z  <= z;
    in_qx <= qx; in_qy <= qy; in_qz <= qz; in_qw <= qw;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random;
    logic [1:0] k;
    k = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
    send_item(k, pick_val(0), pick_val(0), pick_val(0),
              pick_val(1), pick_val(1), pick_val(1), pick_val(1));
  endtask

  // write the whole reference pose; first waits for the pipeline to drain
  task automatic load_ref(logic [31:0] t [3], logic [31:0] q [4]);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    for (int i = REG_TX; i <= REG_QW; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= i[CFG_IDX_W-1:0];
      cfg_data <= (i < REG_QX) ? t[i] : q[i - REG_QX];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_random();
  endtask

  initial begin
    logic [31:0] t [3];
    logic [31:0] q [4];
    rst = 1'b1;
    cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
    start = 1'b0; kind = KIND_COMPOSE;
    in_x = '0; in_y = '0; in_z = '0; in_qx = '0; in_qy = '0; in_qz = '0; in_qw = '0;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items against the identity pose left by reset
    send_item(KIND_COMPOSE, 0, 0, 0, 0, 0, 0, Q_UNIT);
    send_item(KIND_POINT, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 5, 6, 7, 8);
    send_item(KIND_INVERT, 100, -100, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(KIND_INVERT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(KIND_UNUSED, -1, -1, -1, -1, -1, -1, -1);
    send_item(KIND_COMPOSE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    // non-unit quaternion, no normalization
    send_item(KIND_INVERT, 32'sh0001_0000, 0, 0, 32'sh2000_0000, 0, 0, 32'sh2000_0000);

    // extreme reference: everything at maximum, then at minimum
    t = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    q = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_ref(t, q);
    send_item(KIND_POINT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0);
    send_item(KIND_COMPOSE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(KIND_POINT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
    random_phase(150);

    t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    q = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    load_ref(t, q);
    send_item(KIND_POINT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
    send_item(KIND_COMPOSE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    random_phase(150);

    // random reference poses; one phase with no gaps at all
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 3; i++) t[i] = pick_val(0);
      for (int i = 0; i < 4; i++) q[i] = pick_val(1);
      load_ref(t, q);
      gaps_on = (ph != 2);
      random_phase(100);
      // sender holds off until everything is back
      start <= 1'b0;
      do @(posedge clk); while (pending != 0);
      random_phase(80);
    end
    gaps_on = 1'b1;

    // back to identity
    t = '{32'h0, 32'h0, 32'h0};
    q = '{32'h0, 32'h0, 32'h0, Q_UNIT};
    load_ref(t, q);
    random_phase(150);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[quaternion_pose_transform_core] OK");
    end else begin
      $display("[quaternion_pose_transform_core] ERROR");
    end
    $finish;
  end
endmodule
